// ===== rtl/core/brs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_pkg
// Shared constants, codes and types of the balanced range splitter.
// ----------------------------------------------------------------------------
package brs_pkg;

  // Width of the position arithmetic.
  localparam int POSITION_BITS = 32;
  // Largest number of pieces that one gap may be cut into.
  localparam int MAX_PIECES    = 64;

  localparam int POS_W     = POSITION_BITS;
  localparam int DATA_W    = 32;
  localparam int CALC_W    = (POS_W > DATA_W) ? POS_W : DATA_W;
  localparam int PIECE_W   = $clog2(MAX_PIECES + 1);
  localparam int CFG_IDX_W = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LIMIT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH = CFG_IDX_W'(1);

  localparam logic [DATA_W-1:0] BLOCK_LIMIT_RESET  = DATA_W'(16);
  localparam logic [DATA_W-1:0] TOTAL_LENGTH_RESET = DATA_W'(0);

  // Operation codes of an input request.
  localparam logic OP_START  = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV_N,
    FR_DIV_SIZE,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LEAD,
    BK_INNER,
    BK_FINAL
  } back_state_t;

  // One classified request, ready to be expanded into results.
  typedef struct packed {
    logic               lead_zero;   // emit a start at 0 first
    logic [POS_W-1:0]   base;        // start of the gap
    logic [CALC_W-1:0]  short_len;   // size of a short piece
    logic [PIECE_W-1:0] long_cnt;    // number of long pieces
    logic [PIECE_W-1:0] pieces;      // piece count, zero when not split
    logic               final_valid; // emit final_pos at the end
    logic [POS_W-1:0]   final_pos;
    logic               final_err;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [CALC_W-1:0] dividend;
    logic [CALC_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CALC_W-1:0] quotient;
    logic [CALC_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== rtl/core/brs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module brs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  brs_pkg::div_req_t req,
  output brs_pkg::div_rsp_t rsp
);
  import brs_pkg::*;

  localparam int CNT_W = $clog2(CALC_W + 1);

  logic [CALC_W-1:0] rem_r, rem_nxt;
  logic [CALC_W-1:0] quo_r, quo_nxt;
  logic [CALC_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CALC_W:0]   trial;
  logic [CALC_W:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[CALC_W-1]};
    diff     = trial - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[CALC_W-1:0];
        quo_nxt = {quo_r[CALC_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CALC_W-1:0];
        quo_nxt = {quo_r[CALC_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(CALC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== rtl/core/brs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_front
// Accepts requests, tracks the stream state and works out each split.
// ----------------------------------------------------------------------------
module brs_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic                        operation,
  input  logic [brs_pkg::DATA_W-1:0]  start_position,
  input  logic [brs_pkg::DATA_W-1:0]  blk_limit,
  input  logic [brs_pkg::DATA_W-1:0]  total_length,
  output brs_pkg::job_t               job,
  output logic                        job_push,
  input  logic                        job_full
);
  import brs_pkg::*;

  front_state_t       state_r, state_nxt;
  logic [POS_W-1:0]   prev_r, prev_nxt;
  logic               have_r, have_nxt;
  logic               op_r, op_nxt;
  logic [CALC_W-1:0]  gap_r, gap_nxt;
  logic [PIECE_W-1:0] n_r, n_nxt;
  job_t               job_r, job_nxt;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [POS_W-1:0]   tgt;
  logic [POS_W-1:0]   base;
  logic               lead;
  logic               first;
  logic               desc;
  logic [CALC_W-1:0]  gap_in;
  logic [CALC_W-1:0]  mx_eff;
  logic               small_gap;
  logic [CALC_W:0]    n_full;
  logic               n_over;

  brs_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // Classification of the request on the input ports.
  always_comb begin
    tgt       = (operation == OP_START) ? POS_W'(start_position) : POS_W'(total_length);
    lead      = (operation == OP_FINISH) && !have_r;
    base      = lead ? '0 : prev_r;
    first     = (operation == OP_START) && !have_r;
    desc      = tgt < base;
    gap_in    = CALC_W'(tgt - base);
    mx_eff    = (blk_limit == '0) ? CALC_W'(1) : CALC_W'(blk_limit);
    small_gap = gap_in <= mx_eff;
    n_full    = {1'b0, div_rsp.quotient} + (CALC_W + 1)'(div_rsp.remainder != '0);
    n_over    = n_full > (CALC_W + 1)'(MAX_PIECES);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE: begin
        if (push) begin
          state_nxt = (first || desc || small_gap) ? FR_PUSH : FR_DIV_N;
        end
      end
      FR_DIV_N: begin
        if (div_rsp.done) begin
          state_nxt = n_over ? FR_PUSH : FR_DIV_SIZE;
        end
      end
      FR_DIV_SIZE: begin
        if (div_rsp.done) begin
          state_nxt = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!job_full) begin
          state_nxt = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    full             = (state_r != FR_IDLE);
    job_push         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = gap_r;
    div_req.divisor  = mx_eff;
    prev_nxt         = prev_r;
    have_nxt         = have_r;
    op_nxt           = op_r;
    gap_nxt          = gap_r;
    n_nxt            = n_r;
    job_nxt          = job_r;
    case (state_r)
      FR_IDLE: begin
        if (push) begin
          op_nxt              = operation;
          gap_nxt             = gap_in;
          job_nxt.lead_zero   = lead;
          job_nxt.base        = base;
          job_nxt.short_len   = '0;
          job_nxt.long_cnt    = '0;
          job_nxt.pieces      = '0;
          job_nxt.final_pos   = tgt;
          job_nxt.final_err   = 1'b0;
          job_nxt.final_valid = 1'b0;
          if (first) begin
            job_nxt.final_valid = 1'b1;
            prev_nxt            = tgt;
            have_nxt            = 1'b1;
          end else if (desc) begin
            job_nxt.final_valid = 1'b1;
            job_nxt.final_err   = 1'b1;
          end else if (small_gap) begin
            job_nxt.final_valid = (operation == OP_START);
            prev_nxt            = tgt;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = gap_in;
          end
          // A finish always returns the stream to its reset state.
          if (operation == OP_FINISH) begin
            prev_nxt = '0;
            have_nxt = 1'b0;
          end
        end
      end
      FR_DIV_N: begin
        if (div_rsp.done) begin
          if (n_over) begin
            job_nxt.final_valid = 1'b1;
            job_nxt.final_err   = 1'b1;
          end else begin
            n_nxt            = PIECE_W'(n_full);
            div_req.start    = 1'b1;
            div_req.dividend = gap_r;
            div_req.divisor  = CALC_W'(n_full);
          end
        end
      end
      FR_DIV_SIZE: begin
        if (div_rsp.done) begin
          job_nxt.pieces      = n_r;
          job_nxt.short_len   = div_rsp.quotient;
          job_nxt.long_cnt    = PIECE_W'(div_rsp.remainder);
          job_nxt.final_valid = (op_r == OP_START);
          if (op_r == OP_START) begin
            prev_nxt = job_r.final_pos;
          end
        end
      end
      FR_PUSH: begin
        job_push = !job_full;
      end
      default: begin
        job_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      prev_r  <= '0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prev_r  <= prev_nxt;
      have_r  <= have_nxt;
    end
    op_r  <= op_nxt;
    gap_r <= gap_nxt;
    n_r   <= n_nxt;
    job_r <= job_nxt;
  end

  assign job = job_r;

endmodule

// ===== rtl/core/brs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_queue
// Short first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
module brs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  brs_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output brs_pkg::job_t rd_job,
  output logic          empty
);
  import brs_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr;
  logic              do_rd;

  always_comb begin
    full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
    empty      = (cnt_r == '0);
    do_wr      = wr_en && !full;
    do_rd      = rd_en && !empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  assign rd_job = mem_r[rd_ptr_r];

endmodule

// ===== rtl/core/brs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_back
// Expands classified requests into block starts, one result per cycle while the receiver keeps popping.
// ----------------------------------------------------------------------------
module brs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  brs_pkg::job_t              q_job,
  input  logic                       q_empty,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [brs_pkg::DATA_W-1:0] block_start,
  output logic                       last_of_run,
  output logic                       error
);
  import brs_pkg::*;

  back_state_t        state_r, state_nxt;
  job_t               job_r;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [PIECE_W-1:0] idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_pos_r, out_pos_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_err_r, out_err_nxt;

  logic               advance;
  logic               emit;
  logic               split_q;
  logic               split_r;
  logic               inner_end;
  logic [POS_W-1:0]   pos_sum;

  always_comb begin
    advance   = !out_valid_r || pop;
    split_q   = q_job.pieces >= PIECE_W'(2);
    split_r   = job_r.pieces >= PIECE_W'(2);
    inner_end = (idx_r == job_r.pieces - PIECE_W'(1));
    pos_sum   = pos_r + POS_W'(job_r.short_len)
              + POS_W'(PIECE_W'(idx_r - PIECE_W'(1)) < job_r.long_cnt);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_job.lead_zero) begin
            state_nxt = BK_LEAD;
          end else if (split_q) begin
            state_nxt = BK_INNER;
          end else if (q_job.final_valid) begin
            state_nxt = BK_FINAL;
          end
        end
      end
      BK_LEAD: begin
        if (advance) begin
          if (split_r) begin
            state_nxt = BK_INNER;
          end else if (job_r.final_valid) begin
            state_nxt = BK_FINAL;
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      BK_INNER: begin
        if (advance && inner_end) begin
          state_nxt = job_r.final_valid ? BK_FINAL : BK_IDLE;
        end
      end
      BK_FINAL: begin
        if (advance) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // The output register only loads when the result it holds is gone, so a
  // waiting result stays put while the receiver stalls.
  always_comb begin
    q_pop         = 1'b0;
    emit          = 1'b0;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    case (state_r)
      BK_IDLE: begin
        q_pop   = !q_empty;
        pos_nxt = q_job.base;
        idx_nxt = PIECE_W'(1);
      end
      BK_LEAD: begin
        emit = advance;
        if (advance) begin
          out_pos_nxt  = '0;
          out_last_nxt = !split_r && !job_r.final_valid;
          out_err_nxt  = 1'b0;
        end
      end
      BK_INNER: begin
        emit = advance;
        if (advance) begin
          out_pos_nxt  = DATA_W'(pos_sum);
          out_last_nxt = inner_end && !job_r.final_valid;
          out_err_nxt  = 1'b0;
          pos_nxt      = pos_sum;
          idx_nxt      = idx_r + PIECE_W'(1);
        end
      end
      BK_FINAL: begin
        emit = advance;
        if (advance) begin
          out_pos_nxt  = DATA_W'(job_r.final_pos);
          out_last_nxt = 1'b1;
          out_err_nxt  = job_r.final_err;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (q_pop) begin
      job_r <= q_job;
    end
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign empty       = !out_valid_r;
  assign block_start = out_pos_r;
  assign last_of_run = out_last_r;
  assign error       = out_err_r;

endmodule

// ===== rtl/core/balanced_range_splitter.sv =====
`timescale 1ns / 1ps
// Takes an ascending stream of block start requests closed by a finish
// request, and returns the starts with extra starts inserted so that no block
// is longer than the configured block size limit. An oversized gap is cut
// into ceil(gap/limit) near-equal pieces, the first (gap mod pieces) of them
// one longer. A request that splits runs two serial divisions, the first one
// started by the accept, then latches the job and writes it into the queue,
// and only then can the next request be accepted. A request whose gap needs
// too many pieces skips the second division; a request that does not split
// goes straight to the queue write. A full job queue delays the write. The
// result side then delivers one block start a cycle from its output register
// while the receiver keeps popping, after loading each job. The front end and
// the result generator are joined by a two-entry queue, so a new request can
// be worked out while the previous one is still being delivered.
// ----------------------------------------------------------------------------
// balanced_range_splitter
// Top level: configuration registers, front end, job queue and result side.
// ----------------------------------------------------------------------------
module balanced_range_splitter (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input requests.
  input  logic                          push,
  output logic                          full,
  input  logic                          in_operation,
  input  logic [brs_pkg::DATA_W-1:0]    in_start_position,
  // Results.
  output logic                          empty,
  input  logic                          pop,
  output logic [brs_pkg::DATA_W-1:0]    out_block_start,
  output logic                          out_last_of_run,
  output logic                          out_error,
  // Configuration writes.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [brs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brs_pkg::DATA_W-1:0]    cfg_data
);
  import brs_pkg::*;

  logic [DATA_W-1:0] blk_limit_r;
  logic [DATA_W-1:0] total_length_r;

  job_t front_job;
  logic front_push;
  job_t queue_job;
  logic queue_full;
  logic queue_empty;
  logic queue_pop;

  // The configuration port takes a write in every cycle. Writes to an index
  // beyond the register list are accepted and dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_limit_r    <= BLOCK_LIMIT_RESET;
      total_length_r <= TOTAL_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLOCK_LIMIT:  blk_limit_r    <= cfg_data;
        REG_TOTAL_LENGTH: total_length_r <= cfg_data;
        default: begin
          blk_limit_r <= blk_limit_r;
        end
      endcase
    end
  end

  // The front end holds the stream state and decides each split.
  brs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .operation     (in_operation),
    .start_position(in_start_position),
    .blk_limit     (blk_limit_r),
    .total_length  (total_length_r),
    .job           (front_job),
    .job_push      (front_push),
    .job_full      (queue_full)
  );

  brs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (front_push),
    .wr_job(front_job),
    .full  (queue_full),
    .rd_en (queue_pop),
    .rd_job(queue_job),
    .empty (queue_empty)
  );

  // The result side walks each job and presents one start at a time.
  brs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_job      (queue_job),
    .q_empty    (queue_empty),
    .q_pop      (queue_pop),
    .empty      (empty),
    .pop        (pop),
    .block_start(out_block_start),
    .last_of_run(out_last_of_run),
    .error      (out_error)
  );

endmodule
